// ===== rtl/dmrr_pkg.sv =====
`default_nettype none

package dmrr_pkg;

  // Default word width of the random source and of every register.
  localparam int WORD_BITS_DEFAULT = 32;

  // Entries in the queue between the front and the back part.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 1'b1;

  // Sequencer of the back part.
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/dmrr_fifo.sv =====
`default_nettype none

module dmrr_fifo #(
  parameter int WIDTH = dmrr_pkg::WORD_BITS_DEFAULT,
  parameter int DEPTH = dmrr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic                  full,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_BITS'(DEPTH));
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmrr_front.sv =====
`default_nettype none

module dmrr_front #(
  parameter int WORD_BITS = dmrr_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [WORD_BITS-1:0] raw_word,
  input  wire logic                 range_written,
  input  wire logic                 thr_done,
  input  wire logic [WORD_BITS-1:0] thr_rem,
  output logic                      thr_req,
  input  wire logic                 q_full,
  output logic                      q_push
);

  logic [WORD_BITS-1:0] reject_threshold;
  logic                 thr_pending;

  // Nothing is taken while a new threshold is still being worked out.
  assign s_tready = !thr_pending && !q_full;
  assign q_push   = s_tvalid && s_tready && (raw_word < reject_threshold);
  assign thr_req  = thr_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_threshold <= '1;
      thr_pending      <= 1'b0;
    end else begin
      if (range_written) begin
        thr_pending <= 1'b1;
      end else if (thr_done) begin
        thr_pending      <= 1'b0;
        reject_threshold <= '1 - thr_rem;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dmrr_back.sv =====
`default_nettype none

module dmrr_back #(
  parameter int WORD_BITS = dmrr_pkg::WORD_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire logic [WORD_BITS-1:0] q_data,
  output logic                      q_pop,
  input  wire logic                 thr_req,
  output logic                      thr_done,
  output logic [WORD_BITS-1:0]      thr_rem,
  input  wire logic [WORD_BITS-1:0] range_limit,
  input  wire logic [WORD_BITS-1:0] sample_count,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [WORD_BITS-1:0]      m_value,
  output logic                      m_last
);

  localparam int CNT_BITS = $clog2(WORD_BITS);

  dmrr_pkg::back_state_t state, state_next;

  logic [WORD_BITS-1:0] dividend;
  logic [WORD_BITS-1:0] rem;
  logic [CNT_BITS-1:0]  cnt;
  logic                 thr_mode;
  logic [WORD_BITS-1:0] accepted_total;
  logic                 sample_done;

  logic [WORD_BITS:0]   rem_shift;
  logic [WORD_BITS+1:0] trial;
  logic [WORD_BITS-1:0] rem_step;
  logic                 last_step;
  logic [WORD_BITS-1:0] total_inc;
  logic                 last_hit;
  logic                 load_thr;
  logic                 load_word;
  logic                 out_load;

  // One restoring remainder step: bring in the next dividend bit, subtract if it fits.
  assign rem_shift = {rem, dividend[WORD_BITS-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, range_limit};
  assign rem_step  = trial[WORD_BITS+1] ? rem_shift[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
  assign last_step = (cnt == CNT_BITS'(WORD_BITS - 1));
  assign thr_rem   = rem_step;
  assign total_inc = accepted_total + 1'b1;
  assign last_hit  = (total_inc == sample_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmrr_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_thr   = 1'b0;
    load_word  = 1'b0;
    thr_done   = 1'b0;
    out_load   = 1'b0;
    case (state)
      dmrr_pkg::B_IDLE: begin
        if (thr_req) begin
          load_thr   = 1'b1;
          state_next = dmrr_pkg::B_DIV;
        end else if (q_valid) begin
          q_pop = 1'b1;
          // Once the sample is complete, queued words are dropped.
          if (!sample_done) begin
            load_word  = 1'b1;
            state_next = dmrr_pkg::B_DIV;
          end
        end
      end
      dmrr_pkg::B_DIV: begin
        if (last_step) begin
          if (thr_mode) begin
            thr_done   = 1'b1;
            state_next = dmrr_pkg::B_IDLE;
          end else begin
            state_next = dmrr_pkg::B_OUT;
          end
        end
      end
      dmrr_pkg::B_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = dmrr_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = dmrr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_thr) begin
      dividend <= '1;
      rem      <= '0;
      cnt      <= '0;
      thr_mode <= 1'b1;
    end else if (load_word) begin
      dividend <= q_data;
      rem      <= '0;
      cnt      <= '0;
      thr_mode <= 1'b0;
    end else if (state == dmrr_pkg::B_DIV) begin
      dividend <= {dividend[WORD_BITS-2:0], 1'b0};
      rem      <= rem_step;
      cnt      <= cnt + 1'b1;
    end
    if (out_load) begin
      m_value <= rem;
      m_last  <= last_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_total <= '0;
      sample_done    <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_load) begin
        accepted_total <= total_inc;
        m_tvalid       <= 1'b1;
        if (last_hit) begin
          sample_done <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(sample_done))
    else $error("sample_done cleared without reset");

  a_last_marks_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_last) |-> sample_done)
    else $error("last result shown but sample not complete");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_value < range_limit))
    else $error("reduced value not below range_limit");

endmodule

`default_nettype wire

// ===== rtl/debiased_modulo_range_reducer_core.sv =====
`default_nettype none

// Debiased modulo range reducer.
// Raw random words arrive on the s_* stream; each request is compared with the
// rejection threshold and either dropped or queued. Queued words are reduced
// to 0..range_limit-1 by a one-bit-per-cycle restoring remainder unit and
// leave on the m_* stream, with tlast set on the result that completes the
// configured sample count. After that result every word is taken and ignored
// until reset.
// A queued word is fetched, goes through WORD_BITS remainder steps and is then
// loaded into the output register. That shared remainder unit works on one
// word at a time and fetches the next only once the last result is loaded;
// rejected words are dropped at the input and never reach the queue.
// Writing range_limit starts a threshold calculation on the same unit, and the
// input is held off until it is done.
// Reset sets both registers to one, the threshold to all ones, clears the
// count and empties the queue; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register, the back
// part stops, and the queue keeps accepting until it is full.
module debiased_modulo_range_reducer_core #(
  parameter int WORD_BITS   = dmrr_pkg::WORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = dmrr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // raw_word
  input  wire logic [((WORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // reduced_value
  output logic [((WORD_BITS + 7) / 8) * 8 - 1:0]      m_tdata,
  // last_of_sample
  output logic                                       m_tlast,
  input  wire logic                                  cfg_we,
  input  wire logic [dmrr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [WORD_BITS-1:0]                  cfg_data
);

  localparam int TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  logic [WORD_BITS-1:0] range_limit;
  logic [WORD_BITS-1:0] sample_count;
  logic                 range_written;

  logic                 thr_req;
  logic                 thr_done;
  logic [WORD_BITS-1:0] thr_rem;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  logic                 q_full;
  logic [WORD_BITS-1:0] q_data;
  logic [WORD_BITS-1:0] m_value;

  // Configuration registers. A new range triggers a fresh threshold.
  assign range_written = cfg_we && (cfg_index == dmrr_pkg::REG_RANGE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit  <= WORD_BITS'(1);
      sample_count <= WORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        dmrr_pkg::REG_RANGE_LIMIT:  range_limit  <= cfg_data;
        dmrr_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front part: takes requests and drops words at or above the threshold.
  dmrr_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .raw_word     (s_tdata[WORD_BITS-1:0]),
    .range_written(range_written),
    .thr_done     (thr_done),
    .thr_rem      (thr_rem),
    .thr_req      (thr_req),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  // Short queue of accepted words between the two parts.
  dmrr_fifo #(
    .WIDTH(WORD_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(s_tdata[WORD_BITS-1:0]),
    .pop      (q_pop),
    .not_empty(q_valid),
    .full     (q_full),
    .pop_data (q_data)
  );

  // Back part: remainder unit, result count and output register.
  dmrr_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .thr_req     (thr_req),
    .thr_done    (thr_done),
    .thr_rem     (thr_rem),
    .range_limit (range_limit),
    .sample_count(sample_count),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_value     (m_value),
    .m_last      (m_tlast)
  );

  assign m_tdata = TDATA_BITS'(m_value);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// One reduced result as it should leave the block.
typedef struct packed {
  logic [31:0] value;
  logic        last;
} reduction_t;

// Tracks the reducer's registers, threshold and sample count, and holds the
// reduced values still owed by the block, oldest first.
class reduction_scoreboard;
  logic [31:0] range_limit;
  logic [31:0] sample_count;
  logic [31:0] reject_threshold;
  logic [31:0] accepted_total;
  bit          sample_done;
  reduction_t  pending[$];
  int          mismatches;
  int          checked;
  int          rejected;
  int          ignored;

  function new();
    range_limit      = 32'd1;
    sample_count     = 32'd1;
    reject_threshold = threshold_of(32'd1);
    accepted_total   = '0;
    sample_done      = 1'b0;
    mismatches       = 0;
    checked          = 0;
    rejected         = 0;
    ignored          = 0;
  endfunction

  // Largest multiple of the range that does not exceed the all-ones word.
  function logic [31:0] threshold_of(logic [31:0] r);
    if (r == 0) return '0;
    return 32'hFFFF_FFFF - (32'hFFFF_FFFF % r);
  endfunction

  function void write_register(logic [dmrr_pkg::CFG_INDEX_BITS-1:0] index, logic [31:0] data);
    case (index)
      dmrr_pkg::REG_RANGE_LIMIT: begin
        range_limit      = data;
        reject_threshold = threshold_of(data);
      end
      dmrr_pkg::REG_SAMPLE_COUNT: begin
        sample_count = data;
      end
      default: ;
    endcase
  endfunction

  function void note_word(logic [31:0] word);
    reduction_t entry;
    if (sample_done) begin
      ignored++;
      return;
    end
    if (range_limit == 0 || word >= reject_threshold) begin
      rejected++;
      return;
    end
    accepted_total = accepted_total + 32'd1;
    entry.value    = word % range_limit;
    entry.last     = (accepted_total == sample_count);
    if (entry.last) sample_done = 1'b1;
    pending.push_back(entry);
  endfunction

  function void check_result(logic [31:0] value, logic last);
    reduction_t entry;
    if (pending.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual value %h last %b",
               $time, value, last);
      return;
    end
    entry = pending.pop_front();
    checked++;
    if (value !== entry.value) begin
      mismatches++;
      $display("%0t: reduced value wrong, expected %h, actual %h", $time, entry.value, value);
    end
    if (last !== entry.last) begin
      mismatches++;
      $display("%0t: last mark wrong, expected %b, actual %b", $time, entry.last, last);
    end
  endfunction
endclass

module testbench;

  localparam int WORD_BITS    = dmrr_pkg::WORD_BITS_DEFAULT;
  localparam int DATA_BITS    = ((WORD_BITS + 7) / 8) * 8;
  // Room for one word still inside the remainder unit plus the output register.
  localparam int DRAIN_CYCLES = WORD_BITS + 8;
  localparam int IDLE_PERCENT = 31;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_WORDS  = 155;
  localparam int PHASES       = 10;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  logic [DATA_BITS-1:0]                s_tdata   = '0;
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  logic [DATA_BITS-1:0]                m_tdata;
  logic                                m_tlast;
  logic                                cfg_we    = 1'b0;
  logic [dmrr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [WORD_BITS-1:0]                cfg_data  = '0;

  // When quiet is set neither side idles; hold_request asks the receiver for
  // one long hold-off while the sender keeps offering requests.
  bit                  quiet        = 1'b0;
  bit                  hold_request = 1'b0;
  int                  requests_sent   = 0;
  int                  register_writes = 0;
  reduction_scoreboard residues;

  always #5 clk = ~clk;

  debiased_modulo_range_reducer_core #(
    .WORD_BITS(WORD_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Offers one raw word, possibly after a few idle cycles, and returns at the
  // edge where the request is taken. The valid is left high so that a
  // following request can follow back to back.
  task automatic send_word(input logic [31:0] word);
    while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    residues.note_word(word);
    requests_sent++;
  endtask

  // Lets every owed result come out, then waits a little longer so that the
  // block is truly idle before the registers are touched.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (residues.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [dmrr_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    residues.write_register(index, data);
    cfg_we <= 1'b0;
    @(posedge clk);
    register_writes++;
  endtask

  // A directed group: one range setting and four chosen words.
  task automatic directed_group(input logic [31:0] range, input logic [31:0] words [4]);
    settle();
    write_register(dmrr_pkg::REG_RANGE_LIMIT, range);
    foreach (words[k]) send_word(words[k]);
  endtask

  // Raw words: mostly uniform, with a good share just either side of the
  // rejection threshold, near range multiples, and at both ends of the word.
  function automatic logic [31:0] pick_word();
    logic [31:0] thr;
    thr = residues.reject_threshold;
    case ($urandom_range(9))
      5, 6:    return thr - 32'd4 + $urandom_range(7);
      7:       return residues.range_limit * $urandom_range(3) + $urandom_range(2) - 32'd1;
      8:       return $urandom_range(15);
      9:       return 32'hFFFF_FFFF - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_range(int phase);
    logic [31:0] r;
    case (phase)
      0:       r = $urandom;
      1:       r = $urandom_range(16, 2);
      2:       r = 32'd1 << $urandom_range(31, 0);
      3:       r = 32'h8000_0000 + $urandom_range(255, 1);
      4:       r = 32'hFFFF_FFFF;
      5:       r = 32'd1;
      default: r = $urandom >> $urandom_range(31, 0);
    endcase
    if (r == 0) r = 32'd1;
    return r;
  endfunction

  // Receiver: idles at random, takes one long hold-off on request, and checks
  // every result taken against the oldest one owed.
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) residues.check_result(m_tdata[31:0], m_tlast);
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    residues = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The reset sample count of one would end the run at the first accepted
    // word, so the count is opened up first. A count of zero only completes
    // when the counter wraps, which this run never reaches.
    write_register(dmrr_pkg::REG_SAMPLE_COUNT, 32'd0);

    // Directed part: range of one, the full-width range, ranges just above and
    // at half the word, and a small range whose threshold is not all ones.
    // Each group puts words on both sides of the rejection threshold.
    directed_group(32'd1, '{32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA});
    directed_group(32'hFFFF_FFFF, '{32'h0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555});
    directed_group(32'h8000_0001, '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
                                    32'h7FFF_FFFF});
    directed_group(32'd7, '{32'hFFFF_FFFB, 32'hFFFF_FFFC, 32'd6, 32'd7});
    directed_group(32'h8000_0000, '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0});

    // Random part: one range setting per phase, with the sample count moved
    // about mid-run, a phase with no idling and one with a long output stall.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        2: write_register(dmrr_pkg::REG_SAMPLE_COUNT, 32'hFFFF_FFFF);
        // A count already passed: the block has to run on past it.
        5: write_register(dmrr_pkg::REG_SAMPLE_COUNT, 32'd1);
        7: write_register(dmrr_pkg::REG_SAMPLE_COUNT, 32'd0);
        default: ;
      endcase
      write_register(dmrr_pkg::REG_RANGE_LIMIT, pick_range(phase));
      quiet = (phase == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 6 && n == 20) hold_request = 1'b1;
        send_word(pick_word());
      end
    end
    quiet = 1'b0;

    // Final phase: the sample completes a little way ahead, after which every
    // word is taken and must give nothing.
    settle();
    write_register(dmrr_pkg::REG_SAMPLE_COUNT, residues.accepted_total + 32'd20);
    write_register(dmrr_pkg::REG_RANGE_LIMIT, pick_range(1));
    while (!residues.sample_done) send_word(pick_word());
    repeat (30) send_word($urandom);

    settle();
    $display("Covered %0d requests over %0d register writes: %0d results checked,",
             requests_sent, register_writes, residues.checked);
    $display("%0d words rejected above the threshold, %0d ignored after the sample ended.",
             residues.rejected, residues.ignored);
    if (residues.mismatches == 0 && residues.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
